FILE: src/tpq_pkg.sv
// Package for the two-class priority queue: defaults, command and status codes, types.
`default_nettype none

package tpq_pkg;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 10;

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int FID_W   = 10;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEPART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXISTS = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  // One result as it leaves the sequencer
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

FILE: src/tpq_mem.sv
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module tpq_mem #(
  parameter int DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = tpq_pkg::ID_BITS_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/tpq_ctrl.sv
// Command sequencer: scans the entry store and shifts entries in a single pass.
`default_nettype none

module tpq_ctrl #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tpq_pkg::ID_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // command channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tpq_pkg::CMD_W-1:0]       command,
  input  wire logic [tpq_pkg::FID_W-1:0]       entry_id,
  input  wire logic                            entry_class,
  input  wire logic                            urgent,
  input  wire logic                            accepted_class,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tpq_pkg::result_t                     res,
  // entry store
  output logic                                 wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       wr_addr,
  output logic [ID_BITS:0]                     wr_data,
  output logic                                 rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       rd_addr,
  input  wire logic [ID_BITS:0]                rd_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // control registers
  tpq_pkg::state_t state, state_next;
  logic [CW-1:0]   occ, occ_next;
  logic            out_valid_next;
  logic            dv;

  // working registers
  logic [tpq_pkg::CMD_W-1:0]  cmd_r, cmd_r_next;
  logic [ID_BITS-1:0]         id_r, id_r_next;
  logic [ID_BITS:0]           carry, carry_next;
  logic                       ins, ins_next;
  logic                       found, found_next;
  logic [CW-1:0]              rd_idx, rd_idx_next;
  logic [AW-1:0]              d_idx;
  logic [tpq_pkg::STAT_W-1:0] status_r, status_r_next;
  tpq_pkg::result_t           res_next;

  logic          match;
  logic [CW-1:0] occ_upd;

  assign in_ready = (state == tpq_pkg::S_IDLE);
  assign rd_addr  = rd_idx[AW-1:0];

  // Entry count once the command commits
  always_comb begin
    occ_upd = occ;
    if (status_r == tpq_pkg::ST_OK) begin
      if (cmd_r == tpq_pkg::CMD_ADD) begin
        occ_upd = occ + CW'(1);
      end else if (cmd_r == tpq_pkg::CMD_REMOVE || cmd_r == tpq_pkg::CMD_DEPART) begin
        occ_upd = occ - CW'(1);
      end
    end
  end

  // Id compare on returning read data; depart always hits the head
  always_comb begin
    if (cmd_r == tpq_pkg::CMD_DEPART) begin
      match = (d_idx == '0);
    end else begin
      match = (rd_data[ID_BITS-1:0] == id_r);
    end
  end

  // Next state and store accesses. Reads run one entry ahead of writes, so a
  // read never targets the entry written in the same cycle.
  always_comb begin
    state_next     = state;
    occ_next       = occ;
    out_valid_next = out_valid && !out_ready;
    res_next       = res;
    cmd_r_next     = cmd_r;
    id_r_next      = id_r;
    carry_next     = carry;
    ins_next       = ins;
    found_next     = found;
    rd_idx_next    = rd_idx;
    status_r_next  = status_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = d_idx;
    wr_data        = carry;

    case (state)
      tpq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_r_next  = command;
          id_r_next   = ID_BITS'(entry_id);
          carry_next  = {urgent, ID_BITS'(entry_id)};
          ins_next    = 1'b0;
          found_next  = 1'b0;
          rd_idx_next = '0;
          if (command == tpq_pkg::CMD_ADD) begin
            if (entry_class != accepted_class) begin
              status_r_next = tpq_pkg::ST_FAIL;
              state_next    = tpq_pkg::S_DONE;
            end else if (occ == CW'(QUEUE_DEPTH)) begin
              status_r_next = tpq_pkg::ST_FULL;
              state_next    = tpq_pkg::S_DONE;
            end else if (urgent && occ != '0) begin
              state_next = tpq_pkg::S_SCAN;
            end else begin
              state_next = tpq_pkg::S_TAIL;
            end
          end else if (occ == '0) begin
            status_r_next = tpq_pkg::ST_FAIL;
            state_next    = tpq_pkg::S_DONE;
          end else begin
            state_next = tpq_pkg::S_SCAN;
          end
        end
      end

      tpq_pkg::S_SCAN: begin
        rd_en = (rd_idx != occ);
        if (rd_en) begin
          rd_idx_next = rd_idx + CW'(1);
        end
        if (dv) begin
          case (cmd_r)
            tpq_pkg::CMD_ADD: begin
              // urgent insert: drop the carried entry at the first ordinary slot
              if (ins || !rd_data[ID_BITS]) begin
                wr_en      = 1'b1;
                wr_addr    = d_idx;
                wr_data    = carry;
                carry_next = rd_data;
                ins_next   = 1'b1;
              end
            end
            tpq_pkg::CMD_REMOVE, tpq_pkg::CMD_DEPART: begin
              // close the gap behind the removed entry
              if (found) begin
                wr_en   = 1'b1;
                wr_addr = d_idx - AW'(1);
                wr_data = rd_data;
              end
              if (match) begin
                found_next = 1'b1;
              end
            end
            default: begin
              if (match) begin
                found_next = 1'b1;
              end
            end
          endcase
        end
        if (!rd_en && !dv) begin
          if (cmd_r == tpq_pkg::CMD_ADD) begin
            state_next = tpq_pkg::S_TAIL;
          end else begin
            status_r_next = found ? tpq_pkg::ST_OK : tpq_pkg::ST_FAIL;
            state_next    = tpq_pkg::S_DONE;
          end
        end
      end

      tpq_pkg::S_TAIL: begin
        wr_en         = 1'b1;
        wr_addr       = occ[AW-1:0];
        wr_data       = carry;
        status_r_next = tpq_pkg::ST_OK;
        state_next    = tpq_pkg::S_DONE;
      end

      tpq_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          res_next.status = status_r;
          res_next.count  = tpq_pkg::COUNT_W'(occ_upd);
          occ_next        = occ_upd;
          state_next      = tpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tpq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpq_pkg::S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      out_valid <= out_valid_next;
      dv        <= rd_en;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    id_r     <= id_r_next;
    carry    <= carry_next;
    ins      <= ins_next;
    found    <= found_next;
    rd_idx   <= rd_idx_next;
    d_idx    <= rd_idx[AW-1:0];
    status_r <= status_r_next;
    res      <= res_next;
  end

endmodule

`default_nettype wire

FILE: src/two_class_priority_queue.sv
// Top level of the two-class priority queue: class register, sequencer and entry store.
// Remove, depart and exists on a non-empty queue, and an urgent add to a non-empty queue,
// make one pass over the entries through one read port.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset (rst, synchronous): empties the queue, drops any pending result, sets the class to 0.
`default_nettype none

module two_class_priority_queue #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tpq_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_data,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tpq_pkg::CMD_W-1:0]     command,
  input  wire logic [tpq_pkg::FID_W-1:0]     entry_id,
  input  wire logic                          entry_class,
  input  wire logic                          urgent,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tpq_pkg::STAT_W-1:0]         status,
  output logic [tpq_pkg::COUNT_W-1:0]        entry_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic             accepted_class;
  tpq_pkg::result_t res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ID_BITS:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [ID_BITS:0] rd_data;

  // Accepted class register
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_class <= 1'b0;
    end else if (cfg_we) begin
      accepted_class <= cfg_data;
    end
  end

  tpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .entry_id       (entry_id),
    .entry_class    (entry_class),
    .urgent         (urgent),
    .accepted_class (accepted_class),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res            (res),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  tpq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS + 1)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result fields
  assign status      = res.status;
  assign entry_count = res.count;

endmodule

`default_nettype wire

FILE: src/tpq_checker.sv
// Port-level checker for the two-class priority queue, bound to the top level.
`default_nettype none

module tpq_checker #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tpq_pkg::STAT_W-1:0]    status,
  input wire logic [tpq_pkg::COUNT_W-1:0]   entry_count
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == tpq_pkg::ST_OK || status == tpq_pkg::ST_FAIL ||
                   status == tpq_pkg::ST_FULL))
    else $error("undefined status code");

  // A full report comes only with a full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tpq_pkg::ST_FULL |->
      entry_count == tpq_pkg::COUNT_W'(QUEUE_DEPTH))
    else $error("full status with wrong count");

  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (QUEUE_DEPTH > 31) || (int'(entry_count) <= QUEUE_DEPTH))
    else $error("entry count beyond depth");

  // Nothing comes out right after reset, and the sequencer is then ready for a command
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result or busy flag after reset");

endmodule

bind two_class_priority_queue tpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tpq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .entry_count (entry_count)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for two_class_priority_queue: directed table, then random phases.
`default_nettype none

module tb_top;

  localparam int DEPTH       = tpq_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int ROWS        = 16;

  // One row of the directed table; reps > 1 repeats the row with the id counting up
  typedef struct {
    logic [tpq_pkg::CMD_W-1:0]   cmd;
    logic [tpq_pkg::FID_W-1:0]   id;
    logic                        cls;
    logic                        urg;
    int                          reps;
    bit                          typed;
    logic [tpq_pkg::STAT_W-1:0]  st;
    logic [tpq_pkg::COUNT_W-1:0] cnt;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic                        cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [tpq_pkg::CMD_W-1:0]   command;
  logic [tpq_pkg::FID_W-1:0]   entry_id;
  logic                        entry_class;
  logic                        urgent;
  logic                        out_valid;
  logic                        out_ready;
  logic [tpq_pkg::STAT_W-1:0]  status;
  logic [tpq_pkg::COUNT_W-1:0] entry_count;

  // Shadow copy of the queue contents and the class register
  logic [tpq_pkg::FID_W-1:0] held_ids[DEPTH];
  logic                      held_urgent[DEPTH];
  int                        held_count;
  logic                      class_sel;

  tpq_pkg::result_t expected_results[$];
  stim_row_t        directed_rows[ROWS];
  int               mismatch_count;
  int               cycle_count;
  int               gap_pct;
  int               stall_pct;
  bit               quiet;

  two_class_priority_queue i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .entry_id    (entry_id),
    .entry_class (entry_class),
    .urgent      (urgent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  // First position holding id, or held_count if absent
  function automatic int find_entry(input logic [tpq_pkg::FID_W-1:0] id);
    int i;
    for (i = 0; i < held_count; i++) begin
      if (held_ids[i] == id) return i;
    end
    return held_count;
  endfunction

  // Delete one entry and close the gap
  function automatic void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < held_count; i++) begin
      held_ids[i]    = held_ids[i + 1];
      held_urgent[i] = held_urgent[i + 1];
    end
    held_count--;
  endfunction

  // Apply one command to the shadow queue and return status and count
  function automatic tpq_pkg::result_t predict_queue_result(
      input logic [tpq_pkg::CMD_W-1:0] cmd, input logic [tpq_pkg::FID_W-1:0] id,
      input logic cls, input logic urg);
    tpq_pkg::result_t res;
    int pos;
    int i;
    res.status = tpq_pkg::ST_OK;
    case (cmd)
      tpq_pkg::CMD_ADD: begin
        if (cls != class_sel) begin
          res.status = tpq_pkg::ST_FAIL;
        end else if (held_count >= DEPTH) begin
          res.status = tpq_pkg::ST_FULL;
        end else begin
          pos = held_count;
          // urgent goes behind the last urgent entry
          if (urg) begin
            pos = 0;
            while (pos < held_count && held_urgent[pos]) pos++;
          end
          for (i = held_count; i > pos; i--) begin
            held_ids[i]    = held_ids[i - 1];
            held_urgent[i] = held_urgent[i - 1];
          end
          held_ids[pos]    = id;
          held_urgent[pos] = urg;
          held_count++;
        end
      end
      tpq_pkg::CMD_REMOVE: begin
        pos = find_entry(id);
        if (pos < held_count) drop_entry(pos);
        else res.status = tpq_pkg::ST_FAIL;
      end
      tpq_pkg::CMD_DEPART: begin
        if (held_count > 0) drop_entry(0);
        else res.status = tpq_pkg::ST_FAIL;
      end
      default: begin
        if (find_entry(id) >= held_count) res.status = tpq_pkg::ST_FAIL;
      end
    endcase
    res.count = tpq_pkg::COUNT_W'(held_count);
    return res;
  endfunction

  // Ids mostly from a small pool or from held entries so that lookups hit
  function automatic logic [tpq_pkg::FID_W-1:0] pick_entry_id(
      input logic [tpq_pkg::CMD_W-1:0] cmd);
    int r;
    r = $urandom_range(99, 0);
    if ((cmd == tpq_pkg::CMD_REMOVE || cmd == tpq_pkg::CMD_EXISTS) && held_count > 0 && r < 50)
      return held_ids[$urandom_range(held_count - 1, 0)];
    r = $urandom_range(99, 0);
    if (r < 60) return tpq_pkg::FID_W'($urandom_range(15, 0));
    if (r < 80) begin
      case ($urandom_range(3, 0))
        0: return '0;
        1: return '1;
        2: return tpq_pkg::FID_W'(512);
        default: return tpq_pkg::FID_W'(511);
      endcase
    end
    return tpq_pkg::FID_W'($urandom_range(1023, 0));
  endfunction

  // Drive one command from a falling edge, wait for the transfer, record the expectation
  task automatic send_command(input logic [tpq_pkg::CMD_W-1:0] cmd,
      input logic [tpq_pkg::FID_W-1:0] id, input logic cls, input logic urg,
      input bit typed, input tpq_pkg::result_t typed_res);
    tpq_pkg::result_t predicted;
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_id    <= id;
    entry_class <= cls;
    urgent      <= urg;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = predict_queue_result(cmd, id, cls, urg);
    expected_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
    if (!quiet && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk);
    end
  endtask

  // Class register write, only with the queue idle and every result returned
  task automatic write_class(input logic value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    class_sel = value;
  endtask

  // Result side: random stall bursts on out_ready
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    tpq_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no command pending: status %0d, entry_count %0d",
               status, entry_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d", want.count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    tpq_pkg::result_t          typed_res;
    tpq_pkg::result_t          none;
    logic [tpq_pkg::CMD_W-1:0] cmd;
    logic                      cls;
    int                        k;
    int                        n;
    int                        ph;
    int                        r;
    int                        target;

    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = 1'b0;
    in_valid       = 1'b0;
    command        = tpq_pkg::CMD_ADD;
    entry_id       = '0;
    entry_class    = 1'b0;
    urgent         = 1'b0;
    held_count     = 0;
    class_sel      = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    gap_pct        = 20;
    stall_pct      = 20;
    quiet          = 1'b0;
    none           = '0;
    target         = 0;

    // Directed table, run with accepted class 0
    directed_rows = '{
      '{tpq_pkg::CMD_DEPART, 10'd0,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd0},  // empty
      '{tpq_pkg::CMD_REMOVE, 10'd1023, 1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd0},
      '{tpq_pkg::CMD_EXISTS, 10'd0,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd0},
      '{tpq_pkg::CMD_ADD,    10'd0,    1'b1, 1'b1, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd0},  // class
      '{tpq_pkg::CMD_ADD,    10'd0,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_OK,   5'd1},
      '{tpq_pkg::CMD_ADD,    10'd1023, 1'b0, 1'b1, 1,  1'b1, tpq_pkg::ST_OK,   5'd2},
      '{tpq_pkg::CMD_ADD,    10'd5,    1'b0, 1'b1, 1,  1'b1, tpq_pkg::ST_OK,   5'd3},
      '{tpq_pkg::CMD_ADD,    10'd0,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_OK,   5'd4},  // dup id
      '{tpq_pkg::CMD_EXISTS, 10'd1023, 1'b1, 1'b1, 1,  1'b1, tpq_pkg::ST_OK,   5'd4},
      '{tpq_pkg::CMD_EXISTS, 10'd7,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd4},
      '{tpq_pkg::CMD_REMOVE, 10'd0,    1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_OK,   5'd3},
      '{tpq_pkg::CMD_DEPART, 10'd1023, 1'b1, 1'b1, 1,  1'b1, tpq_pkg::ST_OK,   5'd2},
      '{tpq_pkg::CMD_ADD,    10'h2AA,  1'b0, 1'b0, 14, 1'b0, tpq_pkg::ST_OK,   5'd0},  // fill
      '{tpq_pkg::CMD_ADD,    10'd3,    1'b1, 1'b0, 1,  1'b1, tpq_pkg::ST_FAIL, 5'd16},
      '{tpq_pkg::CMD_ADD,    10'd3,    1'b0, 1'b1, 1,  1'b1, tpq_pkg::ST_FULL, 5'd16},
      '{tpq_pkg::CMD_REMOVE, 10'h2B0,  1'b0, 1'b0, 1,  1'b1, tpq_pkg::ST_OK,   5'd15}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_class(1'b0);
    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        typed_res.status = directed_rows[i].st;
        typed_res.count  = directed_rows[i].cnt;
        send_command(directed_rows[i].cmd, directed_rows[i].id + tpq_pkg::FID_W'(k),
                     directed_rows[i].cls, directed_rows[i].urg,
                     directed_rows[i].typed, typed_res);
      end
    end

    // Random phases; each starts with the sender held until all results are back
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) write_class(1'b1);
      else if (ph == 1) write_class(1'b0);
      else write_class(1'($urandom_range(1, 0)));
      case ($urandom_range(2, 0))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(2, 0))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 40;
      endcase
      quiet = (ph == PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // occupancy target steers the queue between empty and full
        if (n % 40 == 0)
          target = ($urandom_range(3, 0) == 0) ? DEPTH : $urandom_range(DEPTH, 0);
        r = $urandom_range(99, 0);
        if (held_count < target)
          cmd = (r < 60) ? tpq_pkg::CMD_ADD : (r < 75) ? tpq_pkg::CMD_REMOVE :
                (r < 85) ? tpq_pkg::CMD_DEPART : tpq_pkg::CMD_EXISTS;
        else
          cmd = (r < 20) ? tpq_pkg::CMD_ADD : (r < 50) ? tpq_pkg::CMD_REMOVE :
                (r < 80) ? tpq_pkg::CMD_DEPART : tpq_pkg::CMD_EXISTS;
        if (cmd == tpq_pkg::CMD_ADD)
          cls = ($urandom_range(99, 0) < 8) ? ~class_sel : class_sel;
        else
          cls = 1'($urandom_range(1, 0));
        send_command(cmd, pick_entry_id(cmd), cls, ($urandom_range(99, 0) < 30),
                     1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/tpq_pkg.sv
src/tpq_mem.sv
src/tpq_ctrl.sv
src/two_class_priority_queue.sv
src/tpq_checker.sv
tb/tb_top.sv
